@@ design/rycc_pkg.sv @@
// Shared widths, operation codes and fixed-point coefficient tables for the color converter.
package rycc_pkg;

    localparam int FRAC_BITS = 20;

    localparam int PIX_W   = 8;
    localparam int OPND_W  = PIX_W + 1;
    localparam int COEF_W  = FRAC_BITS + 3;
    localparam int PROD_W  = OPND_W + COEF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int INT_W   = SUM_W - FRAC_BITS;
    localparam int INT_W1  = INT_W + 1;
    localparam int CHAN_N  = 3;
    localparam int DATA_W  = CHAN_N * PIX_W;

    localparam logic OP_TO_YCC = 1'b0;
    localparam logic OP_TO_RGB = 1'b1;

    localparam logic BT601_RESET = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t coef_mat_t [CHAN_N][CHAN_N];

    // Coefficient magnitudes, rounded to nearest with ties up.
    localparam longint unsigned K601_YR = ((64'd65481 << FRAC_BITS) + 64'd127500) / 64'd255000;
    localparam longint unsigned K601_YG = ((64'd128553 << FRAC_BITS) + 64'd127500) / 64'd255000;
    localparam longint unsigned K601_YB = ((64'd24966 << FRAC_BITS) + 64'd127500) / 64'd255000;
    localparam longint unsigned K601_CBR =
        ((64'd37796864 << FRAC_BITS) + 64'd127500000) / 64'd255000000;
    localparam longint unsigned K601_CBG =
        ((64'd74203136 << FRAC_BITS) + 64'd127500000) / 64'd255000000;
    localparam longint unsigned K_HALF112 = ((64'd112 << FRAC_BITS) + 64'd127) / 64'd255;
    localparam longint unsigned K601_CRG =
        ((64'd93786112 << FRAC_BITS) + 64'd127500000) / 64'd255000000;
    localparam longint unsigned K601_CRB =
        ((64'd18213888 << FRAC_BITS) + 64'd127500000) / 64'd255000000;

    localparam longint unsigned K709_YR = ((64'd465594 << FRAC_BITS) + 64'd1275000) / 64'd2550000;
    localparam longint unsigned K709_YG =
        ((64'd1566288 << FRAC_BITS) + 64'd1275000) / 64'd2550000;
    localparam longint unsigned K709_YB = ((64'd158118 << FRAC_BITS) + 64'd1275000) / 64'd2550000;
    localparam longint unsigned K709_CBR = ((64'd476224 << FRAC_BITS) + 64'd2365890) / 64'd4731780;
    localparam longint unsigned K709_CBG =
        ((64'd1602048 << FRAC_BITS) + 64'd2365890) / 64'd4731780;
    localparam longint unsigned K709_CRG =
        ((64'd1602048 << FRAC_BITS) + 64'd2007870) / 64'd4015740;
    localparam longint unsigned K709_CRB = ((64'd161728 << FRAC_BITS) + 64'd2007870) / 64'd4015740;

    localparam longint unsigned KINV_Y =
        ((64'd1164383562 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K601_RCR =
        ((64'd1596026317 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K601_GCR =
        ((64'd8129674985 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned K601_GCB =
        ((64'd3917615979 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned K601_BCB =
        ((64'd2017232218 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K709_RCR =
        ((64'd1792741071 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K709_GCR =
        ((64'd5329093286 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned K709_GCB =
        ((64'd2132486143 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned K709_BCB =
        ((64'd2112401786 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;

    localparam coef_t CZ = '0;

    // Returns the signed 3x3 matrix; row is the output channel, column the operand.
    function automatic coef_mat_t coef_sel(input logic op, input logic bt601);
        coef_mat_t m;
        if (op == OP_TO_YCC) begin
            if (bt601) begin
                m = '{'{coef_t'(K601_YR), coef_t'(K601_YG), coef_t'(K601_YB)},
                      '{-coef_t'(K601_CBR), -coef_t'(K601_CBG), coef_t'(K_HALF112)},
                      '{coef_t'(K_HALF112), -coef_t'(K601_CRG), -coef_t'(K601_CRB)}};
            end
            else begin
                m = '{'{coef_t'(K709_YR), coef_t'(K709_YG), coef_t'(K709_YB)},
                      '{-coef_t'(K709_CBR), -coef_t'(K709_CBG), coef_t'(K_HALF112)},
                      '{coef_t'(K_HALF112), -coef_t'(K709_CRG), -coef_t'(K709_CRB)}};
            end
        end
        else begin
            if (bt601) begin
                m = '{'{coef_t'(KINV_Y), CZ, coef_t'(K601_RCR)},
                      '{coef_t'(KINV_Y), -coef_t'(K601_GCB), -coef_t'(K601_GCR)},
                      '{coef_t'(KINV_Y), coef_t'(K601_BCB), CZ}};
            end
            else begin
                m = '{'{coef_t'(KINV_Y), CZ, coef_t'(K709_RCR)},
                      '{coef_t'(KINV_Y), -coef_t'(K709_GCB), -coef_t'(K709_GCR)},
                      '{coef_t'(KINV_Y), coef_t'(K709_BCB), CZ}};
            end
        end
        return m;
    endfunction

endpackage

@@ design/rgb_ycbcr_color_converter.sv @@
// Top level of the four-stage RGB / limited-range YCbCr color converter.
//
//   Port group     Dir  Payload
//   s_axis_*       in   tdata: in_first, in_second, in_third; tuser: op
//   m_axis_*       out  tdata: out_first, out_second, out_third
//   cfg_wr_*       in   use_bt601, written when cfg_wr_en is high
//
// Each transaction passes four register stages, and a new transaction can enter every cycle
// while the output does not stall: operand and coefficient select, nine multiplies,
// three-term sum, then rounding, offset and clamp in the output register.
// Reset clears all stage valid bits and sets use_bt601 to one.
// A stall at the output holds each full stage; empty stages keep filling.
module rgb_ycbcr_color_converter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Bits from low: in_first, in_second, in_third.
    input  logic [rycc_pkg::DATA_W-1:0]   s_axis_tdata,
    // Bits from low: op.
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Bits from low: out_first, out_second, out_third.
    output logic [rycc_pkg::DATA_W-1:0]   m_axis_tdata
);

    localparam int N  = rycc_pkg::CHAN_N;
    localparam int PW = rycc_pkg::PIX_W;
    localparam int IW = rycc_pkg::INT_W1;
    localparam int F  = rycc_pkg::FRAC_BITS;

    localparam logic signed [rycc_pkg::OPND_W-1:0] Y_OFS_IN = 16;
    localparam logic signed [rycc_pkg::OPND_W-1:0] C_OFS_IN = 128;
    localparam logic signed [rycc_pkg::SUM_W-1:0] HALF =
        rycc_pkg::SUM_W'(1) <<< (F - 1);

    localparam logic signed [IW-1:0] Y_OFS   = 16;
    localparam logic signed [IW-1:0] C_OFS   = 128;
    localparam logic signed [IW-1:0] ZERO_V  = 0;
    localparam logic signed [IW-1:0] Y_MIN   = 16;
    localparam logic signed [IW-1:0] Y_MAX   = 235;
    localparam logic signed [IW-1:0] C_MIN   = 16;
    localparam logic signed [IW-1:0] C_MAX   = 240;
    localparam logic signed [IW-1:0] RGB_MAX = 255;

    logic use_bt601_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic op1_reg, op2_reg, op3_reg, op4_reg;
    logic signed [rycc_pkg::OPND_W-1:0] opnd1_reg [N];
    logic signed [rycc_pkg::OPND_W-1:0] opnd1_next [N];
    rycc_pkg::coef_mat_t coef1_reg;
    rycc_pkg::coef_mat_t coef1_next;
    logic signed [rycc_pkg::PROD_W-1:0] prod2_reg [N][N];
    logic signed [rycc_pkg::SUM_W-1:0]  sum3_reg [N];
    logic signed [rycc_pkg::SUM_W-1:0]  sum3_next [N];
    logic [PW-1:0] out4_reg [N];
    logic [PW-1:0] out4_next [N];

    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {out4_reg[2], out4_reg[1], out4_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_bt601_reg <= rycc_pkg::BT601_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                use_bt601_reg <= cfg_wr_data;
            end
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage one: operands, with input offsets removed for conversion to RGB, coefficient matrix selected.
    always_comb
    begin
        coef1_next = rycc_pkg::coef_sel(s_axis_tuser, use_bt601_reg);
        for (int i = 0; i < N; i++)
        begin
            opnd1_next[i] = $signed({1'b0, s_axis_tdata[i*PW +: PW]});
        end
        if (s_axis_tuser == rycc_pkg::OP_TO_RGB)
        begin
            opnd1_next[0] = opnd1_next[0] - Y_OFS_IN;
            opnd1_next[1] = opnd1_next[1] - C_OFS_IN;
            opnd1_next[2] = opnd1_next[2] - C_OFS_IN;
        end
    end

    // Stage three: three-term sum plus one half.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            sum3_next[i] = rycc_pkg::SUM_W'(prod2_reg[i][0]) + rycc_pkg::SUM_W'(prod2_reg[i][1])
                         + rycc_pkg::SUM_W'(prod2_reg[i][2]) + HALF;
        end
    end

    // Stage four: truncation toward zero, output offset and clamp.
    always_comb
    begin
        logic signed [IW-1:0] iv;
        logic signed [IW-1:0] ofs;
        logic signed [IW-1:0] lo;
        logic signed [IW-1:0] hi;
        logic                 inc;
        for (int i = 0; i < N; i++)
        begin
            inc = sum3_reg[i][rycc_pkg::SUM_W-1] && (sum3_reg[i][F-1:0] != '0);
            if (op3_reg == rycc_pkg::OP_TO_YCC)
            begin
                ofs = (i == 0) ? Y_OFS : C_OFS;
                lo  = (i == 0) ? Y_MIN : C_MIN;
                hi  = (i == 0) ? Y_MAX : C_MAX;
            end
            else
            begin
                ofs = ZERO_V;
                lo  = ZERO_V;
                hi  = RGB_MAX;
            end
            iv = IW'($signed(sum3_reg[i][rycc_pkg::SUM_W-1:F])) + $signed({{(IW-1){1'b0}}, inc})
               + ofs;
            if (iv < lo)
            begin
                iv = lo;
            end
            else if (iv > hi)
            begin
                iv = hi;
            end
            out4_next[i] = iv[PW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            op1_reg   <= s_axis_tuser;
            opnd1_reg <= opnd1_next;
            coef1_reg <= coef1_next;
        end
        if (rdy2)
        begin
            op2_reg <= op1_reg;
            for (int i = 0; i < N; i++)
            begin
                for (int j = 0; j < N; j++)
                begin
                    prod2_reg[i][j] <= opnd1_reg[j] * coef1_reg[i][j];
                end
            end
        end
        if (rdy3)
        begin
            op3_reg  <= op2_reg;
            sum3_reg <= sum3_next;
        end
        if (rdy4)
        begin
            op4_reg  <= op3_reg;
            out4_reg <= out4_next;
        end
    end

    // The input side only stalls when every stage holds a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty pipeline stage");

    // A result appears only after the sum stage held a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(v3_reg))
        else $error("output became valid without a transaction in the sum stage");

    // YCbCr results stay within the limited range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && op4_reg == rycc_pkg::OP_TO_YCC) |->
            (out4_reg[0] >= 8'd16 && out4_reg[0] <= 8'd235 &&
             out4_reg[1] >= 8'd16 && out4_reg[1] <= 8'd240 &&
             out4_reg[2] >= 8'd16 && out4_reg[2] <= 8'd240))
        else $error("YCbCr result outside the limited range");

    // A transaction accepted while stage one is empty occupies stage one in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !v1_reg) |=> v1_reg)
        else $error("accepted transaction lost in stage one");

endmodule
